/* rtl/polynomial_multiply_assert.svh */
// Assertion macros used by the polynomial multiplier port-level checker.
`ifndef POLYNOMIAL_MULTIPLY_ASSERT_SVH
`define POLYNOMIAL_MULTIPLY_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/polymul_pkg.sv */
// Shared constants and types of the polynomial multiplier.
package polymul_pkg;

    localparam int COEFF_W   = 16;
    localparam int PROD_W    = 37;
    localparam int POW_W     = 6;
    localparam int CFG_W     = 6;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEN = 2'd1;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    // Travels with each pair of store reads into the multiply-accumulate unit.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             final_term;
        logic [POW_W-1:0] power;
    } t_mac_tag;

endpackage

/* rtl/polymul_ram.sv */
// Single-port-write, single-port-read coefficient store with registered read data.
module polymul_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/polymul_seq.sv */
// Load counter and product sequencer: stores coefficients, then walks every (k, i) term.
module polymul_seq
    import polymul_pkg::*;
#(
    parameter int MAX_TERMS = 32,
    localparam int AW = $clog2(MAX_TERMS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_wr_first,
    output logic                 o_wr_second,
    output logic [AW-1:0]        o_wr_addr,
    output logic [AW-1:0]        o_rd_addr_a,
    output logic [AW-1:0]        o_rd_addr_b,
    output t_mac_tag             o_tag
);

    localparam logic [CFG_W-1:0] MAX_LEN   = CFG_W'(MAX_TERMS);
    localparam logic [1:0]       DRAIN_CYC = 2'd2;

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_first_len, n_first_len;
    logic [CFG_W-1:0] r_second_len, n_second_len;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [POW_W-1:0] r_k, n_k;
    logic [POW_W-1:0] r_i, n_i;
    logic [1:0]       r_drain, n_drain;
    t_mac_tag         r_tag, n_tag;

    logic [CFG_W-1:0] len_m, len_n;
    logic [CNT_W-1:0] len_sum, sum_m2, cnt_inc, load_off;
    logic [POW_W-1:0] k_last, i_lo, i_hi, next_lo, b_idx;
    logic             accept, in_first, is_first, is_last, is_final;

    always_comb begin
        len_m = (r_first_len == '0) ? CFG_W'(1) :
                (r_first_len > MAX_LEN) ? MAX_LEN : r_first_len;
        len_n = (r_second_len == '0) ? CFG_W'(1) :
                (r_second_len > MAX_LEN) ? MAX_LEN : r_second_len;
    end

    assign len_sum  = {1'b0, len_m} + {1'b0, len_n};
    assign sum_m2   = len_sum - CNT_W'(2);
    assign k_last   = sum_m2[POW_W-1:0];
    assign cnt_inc  = r_cnt + CNT_W'(1);
    assign load_off = r_cnt - {1'b0, len_m};

    // Term range of power k: i from max(0, k-n+1) to min(k, m-1).
    assign i_lo    = (r_k >= len_n - CFG_W'(1)) ? r_k - (len_n - CFG_W'(1)) : '0;
    assign i_hi    = (r_k < len_m - CFG_W'(1)) ? r_k : len_m - CFG_W'(1);
    assign next_lo = (r_k >= len_n - CFG_W'(1)) ? r_k - len_n + POW_W'(2) : '0;
    assign b_idx   = r_k - r_i;

    assign is_first = (r_i == i_lo);
    assign is_last  = (r_i == i_hi);
    assign is_final = is_last && (r_k == k_last);

    assign busy     = (r_state != ST_LOAD);
    assign accept   = start && (r_state == ST_LOAD);
    assign in_first = (r_cnt < {1'b0, len_m});

    assign o_wr_first  = accept && in_first;
    assign o_wr_second = accept && !in_first;
    assign o_wr_addr   = in_first ? r_cnt[AW-1:0] : load_off[AW-1:0];
    assign o_rd_addr_a = r_i[AW-1:0];
    assign o_rd_addr_b = b_idx[AW-1:0];
    assign o_tag       = r_tag;

    always_comb begin
        n_state      = r_state;
        n_first_len  = r_first_len;
        n_second_len = r_second_len;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_i          = r_i;
        n_drain      = r_drain;

        n_tag.valid      = (r_state == ST_RUN);
        n_tag.first      = is_first;
        n_tag.last       = is_last;
        n_tag.final_term = is_final;
        n_tag.power      = r_k;

        unique case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (cnt_inc == len_sum) begin
                        n_cnt   = '0;
                        n_k     = '0;
                        n_i     = '0;
                        n_state = ST_RUN;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            ST_RUN: begin
                if (is_last) begin
                    if (is_final) begin
                        n_state = ST_DRAIN;
                        n_drain = DRAIN_CYC;
                    end else begin
                        n_k = r_k + POW_W'(1);
                        n_i = next_lo;
                    end
                end else begin
                    n_i = r_i + POW_W'(1);
                end
            end
            ST_DRAIN: begin
                // Hold busy until the final sum has left the accumulator.
                if (r_drain == '0) begin
                    n_state = ST_LOAD;
                end else begin
                    n_drain = r_drain - 2'd1;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        // A length write drops any partly loaded pair.
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST_LEN: begin
                    n_first_len = i_cfg_data;
                    n_cnt       = '0;
                end
                CFG_SECOND_LEN: begin
                    n_second_len = i_cfg_data;
                    n_cnt        = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_first_len  <= CFG_W'(1);
            r_second_len <= CFG_W'(1);
            r_cnt        <= '0;
            r_k          <= '0;
            r_i          <= '0;
            r_drain      <= '0;
            r_tag        <= '0;
        end else begin
            r_state      <= n_state;
            r_first_len  <= n_first_len;
            r_second_len <= n_second_len;
            r_cnt        <= n_cnt;
            r_k          <= n_k;
            r_i          <= n_i;
            r_drain      <= n_drain;
            r_tag        <= n_tag;
        end
    end

endmodule

/* rtl/polymul_mac.sv */
// Multiply-accumulate unit: one product per cycle, summed per power, result registered.
module polymul_mac
    import polymul_pkg::*;
#(
    parameter int COEFF_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_tag                 i_tag,
    input  logic [COEFF_BITS-1:0]    i_coeff_a,
    input  logic [COEFF_BITS-1:0]    i_coeff_b,
    output logic                     o_valid,
    output logic signed [PROD_W-1:0] o_product,
    output logic [POW_W-1:0]         o_power,
    output logic                     o_last
);

    localparam int PW = 2 * COEFF_BITS;

    t_mac_tag                 r_tag2;
    logic signed [PW-1:0]     r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] r_product;
    logic [POW_W-1:0]         r_power;
    logic                     r_last;
    logic                     r_valid;

    logic signed [PROD_W-1:0] prod_ext;
    logic signed [PROD_W-1:0] acc_sum;

    // Low PROD_W bits of the exact sum only depend on the low bits of each product.
    if (PW >= PROD_W) begin : g_trunc
        assign prod_ext = r_prod[PROD_W-1:0];
    end else begin : g_sext
        assign prod_ext = {{(PROD_W - PW){r_prod[PW-1]}}, r_prod};
    end

    assign acc_sum = (r_tag2.first ? '0 : r_acc) + prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_tag2  <= i_tag;
            r_valid <= r_tag2.valid && r_tag2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_coeff_a) * $signed(i_coeff_b);
        if (r_tag2.valid) begin
            r_acc <= acc_sum;
            if (r_tag2.last) begin
                r_product <= acc_sum;
                r_power   <= r_tag2.power;
                r_last    <= r_tag2.final_term;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_product = r_product;
    assign o_power   = r_power;
    assign o_last    = r_last;

endmodule

/* rtl/polynomial_multiply.sv */
// Top level of the schoolbook polynomial multiplier.
//
// Load: pulse start with a coefficient while busy is low; each transfer takes
// one cycle. The first first_len transfers fill the first polynomial, the next
// second_len the second one, lowest power first.
// Compute: the transfer of the last coefficient raises busy. One multiply-
// accumulate unit, fed by one read port on each coefficient store, handles one
// term per cycle, m*n terms in all for lengths m and n.
// Results appear on o_valid for one cycle each, power 0 first, with
// o_last_term on power m+n-2; busy drops in the cycle after the last result.
// Results cannot be held off: the receiver takes each in the cycle it shows.
// Configuration: write first_len (index 0) or second_len (index 1) through
// i_cfg_we while busy is low; a write restarts loading at the first polynomial.
// Reset: synchronous, active low; lengths return to 1 and loading restarts.
// The stores are not cleared; every entry is loaded before it is read.
module polynomial_multiply
    import polymul_pkg::*;
#(
    parameter int MAX_TERMS  = 32,
    parameter int COEFF_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [COEFF_W-1:0] i_coefficient,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output logic                     o_valid,
    output logic signed [PROD_W-1:0] o_product_coefficient,
    output logic [POW_W-1:0]         o_power_index,
    output logic                     o_last_term
);

    localparam int AW = $clog2(MAX_TERMS);

    logic [COEFF_BITS-1:0] coeff_in;
    logic [COEFF_BITS-1:0] rd_a, rd_b;
    logic                  wr_first, wr_second;
    logic [AW-1:0]         wr_addr, rd_addr_a, rd_addr_b;
    t_mac_tag              tag;

    // Narrow stores keep the low bits; wide stores see the port as unsigned.
    if (COEFF_BITS <= COEFF_W) begin : g_narrow
        assign coeff_in = i_coefficient[COEFF_BITS-1:0];
    end else begin : g_wide
        assign coeff_in = {{(COEFF_BITS - COEFF_W){1'b0}}, i_coefficient};
    end

    polymul_seq #(
        .MAX_TERMS(MAX_TERMS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_wr_first (wr_first),
        .o_wr_second(wr_second),
        .o_wr_addr  (wr_addr),
        .o_rd_addr_a(rd_addr_a),
        .o_rd_addr_b(rd_addr_b),
        .o_tag      (tag)
    );

    polymul_ram #(
        .DEPTH(MAX_TERMS),
        .WIDTH(COEFF_BITS)
    ) u_first_store (
        .i_clk  (i_clk),
        .i_we   (wr_first),
        .i_waddr(wr_addr),
        .i_wdata(coeff_in),
        .i_raddr(rd_addr_a),
        .o_rdata(rd_a)
    );

    polymul_ram #(
        .DEPTH(MAX_TERMS),
        .WIDTH(COEFF_BITS)
    ) u_second_store (
        .i_clk  (i_clk),
        .i_we   (wr_second),
        .i_waddr(wr_addr),
        .i_wdata(coeff_in),
        .i_raddr(rd_addr_b),
        .o_rdata(rd_b)
    );

    polymul_mac #(
        .COEFF_BITS(COEFF_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (tag),
        .i_coeff_a(rd_a),
        .i_coeff_b(rd_b),
        .o_valid  (o_valid),
        .o_product(o_product_coefficient),
        .o_power  (o_power_index),
        .o_last   (o_last_term)
    );

endmodule

/* rtl/polymul_checker.sv */
// Port-level checker for the polynomial multiplier, bound to the top level.
`include "polynomial_multiply_assert.svh"

module polymul_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_valid,
    input logic o_last_term
);

    `PM_ASSERT_SAME(a_result_while_busy, o_valid, busy, "result strobe while idle")

    `PM_ASSERT_NEXT(a_last_ends_phase, o_valid && o_last_term, !o_valid && !busy, "product phase did not end after the last term")

    `PM_ASSERT_SAME(a_idle_after_last, $fell(busy) && $past(i_rst_n), $past(o_valid && o_last_term), "busy dropped without a last term")

endmodule

bind polynomial_multiply polymul_checker u_checker (.*);

/* test/testbench.sv */
// Self-checking testbench for the polynomial multiplier: random and directed pairs against a predictor.
module testbench;
    import polymul_pkg::*;

    localparam int MAX_TERMS     = 32;
    localparam int ITEM_TARGET   = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 6000;

    localparam logic signed [COEFF_W-1:0] COEFF_MIN = 16'sh8000;
    localparam logic signed [COEFF_W-1:0] COEFF_MAX = 16'sh7FFF;

    // Indexes that decode to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic signed [PROD_W-1:0] prod;
        logic [POW_W-1:0]         power;
        logic                     last;
    } t_product_term;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [COEFF_W-1:0] i_coefficient = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_W-1:0]          i_cfg_data = '0;
    logic                      o_valid;
    logic signed [PROD_W-1:0]  o_product_coefficient;
    logic [POW_W-1:0]          o_power_index;
    logic                      o_last_term;

    polynomial_multiply i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_coefficient         (i_coefficient),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .o_valid               (o_valid),
        .o_product_coefficient (o_product_coefficient),
        .o_power_index         (o_power_index),
        .o_last_term           (o_last_term)
    );

    logic signed [COEFF_W-1:0] coeff_queue[$];
    t_product_term             product_queue[$];

    int unsigned issue_count = 0;
    int unsigned accept_count = 0;
    int          stall_cycles = 0;
    int          idle_pct = 0;
    int          errors = 0;

    // Predictor copy of the block state.
    logic [CFG_W-1:0]          first_len_q;
    logic [CFG_W-1:0]          second_len_q;
    logic signed [COEFF_W-1:0] first_terms[MAX_TERMS];
    logic signed [COEFF_W-1:0] second_terms[MAX_TERMS];
    int                        loaded;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int span_of(input logic [CFG_W-1:0] len);
        if (len == 0) return 1;
        if (len > MAX_TERMS) return MAX_TERMS;
        return int'(len);
    endfunction

    // Store one coefficient; on the last of a pair, queue the whole convolution.
    task automatic absorb_coefficient(input logic signed [COEFF_W-1:0] c);
        int m;
        int n;
        int k;
        int i;
        longint acc;
        longint fa;
        longint sb;
        t_product_term term;
        m = span_of(first_len_q);
        n = span_of(second_len_q);
        if (loaded >= m + n) loaded = 0;
        if (loaded < m) first_terms[loaded] = c;
        else second_terms[loaded - m] = c;
        loaded++;
        if (loaded == m + n) begin
            loaded = 0;
            for (k = 0; k < m + n - 1; k++) begin
                acc = 0;
                for (i = 0; i < m; i++) begin
                    if (k >= i && k - i < n) begin
                        fa = first_terms[i];
                        sb = second_terms[k - i];
                        acc += fa * sb;
                    end
                end
                term.prod  = acc[PROD_W-1:0];
                term.power = k[POW_W-1:0];
                term.last  = (k == m + n - 2);
                product_queue.push_back(term);
            end
        end
    endtask

    task automatic report_mismatch(input string field, input longint want, input longint got);
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    // Driver: present the next coefficient once the current one has transferred.
    always @(negedge i_clk) begin
        if (!start || accept_count == issue_count) begin
            if (i_rst_n && coeff_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_coefficient <= coeff_queue.pop_front();
                start         <= 1'b1;
                issue_count   <= issue_count + 1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: track config writes and coefficient transfers, check each product term.
    always @(posedge i_clk) begin
        t_product_term want;
        if (!i_rst_n) begin
            first_len_q  = 6'd1;
            second_len_q = 6'd1;
            loaded       = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FIRST_LEN) begin
                    first_len_q = i_cfg_data;
                    loaded      = 0;
                end else if (i_cfg_index == CFG_SECOND_LEN) begin
                    second_len_q = i_cfg_data;
                    loaded       = 0;
                end
            end
            if (start && !busy) begin
                accept_count <= accept_count + 1;
                absorb_coefficient(i_coefficient);
            end
            if (o_valid) begin
                if (product_queue.size() == 0) begin
                    $display("%0t unexpected product term: actual power %0d value %0d",
                             $time, o_power_index, o_product_coefficient);
                    errors++;
                end else begin
                    want = product_queue.pop_front();
                    if (o_product_coefficient !== want.prod)
                        report_mismatch("product_coefficient", want.prod, o_product_coefficient);
                    if (o_power_index !== want.power)
                        report_mismatch("power_index", want.power, o_power_index);
                    if (o_last_term !== want.last)
                        report_mismatch("last_term", want.last, o_last_term);
                end
            end
        end
        if (!i_rst_n || i_cfg_we || (start && !busy) || o_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    function automatic logic signed [COEFF_W-1:0] pick_coefficient();
        case ($urandom_range(9))
            0: return COEFF_MIN;
            1: return COEFF_MAX;
            2: return '0;
            3: return -16'sd1;
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_length();
        case ($urandom_range(19))
            0: return '0;
            1: return CFG_W'(MAX_TERMS);
            2: return CFG_W'($urandom_range(MAX_TERMS + 1, 63));
            3: return CFG_W'($urandom_range(7, MAX_TERMS - 1));
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic program_lengths(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] b,
                                   output int pair_size);
        write_reg(CFG_FIRST_LEN, a);
        write_reg(CFG_SECOND_LEN, b);
        pair_size = span_of(a) + span_of(b);
    endtask

    // Wait for every transfer and every product term, then let the block go idle.
    task automatic settle();
        while (coeff_queue.size() != 0 || accept_count != issue_count ||
               product_queue.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_random(input int count, inout int tally);
        repeat (count) coeff_queue.push_back(pick_coefficient());
        tally += count;
    endtask

    initial begin
        int pair_size;
        int random_items;
        int phase;
        int pairs;
        int cut;
        int idle_plan[3];
        logic [CFG_W-1:0] len_a;
        idle_plan = '{0, 78, 14};
        random_items = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset lengths are one by one: extreme scalar products.
        idle_pct = 0;
        coeff_queue.push_back(COEFF_MAX);
        coeff_queue.push_back(COEFF_MIN);
        coeff_queue.push_back(COEFF_MIN);
        coeff_queue.push_back(COEFF_MIN);
        settle();

        // Zero length behaves as one.
        program_lengths(6'd0, 6'd2, pair_size);
        coeff_queue.push_back(COEFF_MAX);
        coeff_queue.push_back(COEFF_MAX);
        coeff_queue.push_back(COEFF_MIN);
        settle();

        // Abandon a partly loaded pair by a length write.
        program_lengths(6'd3, 6'd2, pair_size);
        coeff_queue.push_back(16'sd1234);
        coeff_queue.push_back(-16'sd77);
        settle();
        write_reg(CFG_SECOND_LEN, 6'd1);
        coeff_queue.push_back(-16'sd1);
        coeff_queue.push_back(16'sd2);
        coeff_queue.push_back(COEFF_MIN);
        coeff_queue.push_back(COEFF_MAX);
        settle();

        // A write to an unused index leaves loading where it was.
        write_reg(CFG_FIRST_LEN, 6'd2);
        coeff_queue.push_back(16'sd300);
        settle();
        write_reg(CFG_SPARE_A, CFG_W'($urandom));
        coeff_queue.push_back(-16'sd5);
        coeff_queue.push_back(16'sd9);
        settle();
        write_reg(CFG_SPARE_B, CFG_W'($urandom));

        // Largest magnitude: full-length operands of all most-negative values.
        idle_pct = 14;
        program_lengths(6'd63, CFG_W'(MAX_TERMS), pair_size);
        repeat (pair_size) coeff_queue.push_back(COEFF_MIN);
        random_items += pair_size;
        settle();

        phase = 0;
        while (random_items < ITEM_TARGET) begin
            idle_pct = idle_plan[phase % 3];
            phase++;
            len_a = pick_length();
            program_lengths(len_a, pick_length(), pair_size);
            pairs = $urandom_range(1, 3);
            repeat (pairs) begin
                if (pair_size > 1 && $urandom_range(9) == 0) begin
                    // Broken pair: load part of it, then restart by rewriting a length.
                    cut = $urandom_range(1, pair_size - 1);
                    push_random(cut, random_items);
                    settle();
                    write_reg(CFG_FIRST_LEN, len_a);
                end
                push_random(pair_size, random_items);
            end
            settle();
        end

        settle();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
